### rtl/ehms_pkg.sv
package ehms_pkg;

	localparam int DIV_W       = 32;
	localparam int REM_W       = 6;
	localparam int PRE_W       = 30;
	localparam int RECIP_W     = 32;
	localparam int RECIP_SHIFT = 34;
	localparam int QUO_W       = 28;

	localparam logic [REM_W-1:0] DIV_SIXTY = 6'd60;
	localparam logic [REM_W-1:0] DIV_TEN   = 6'd10;

	localparam logic [RECIP_W-1:0] RECIP_FIFTEEN = 32'h4444_4445;
	localparam logic [RECIP_W-1:0] RECIP_FIVE    = 32'hCCCC_CCCD;

	localparam logic [6:0] CH_ZERO = 7'h30;
	localparam logic [6:0] CH_H    = 7'h68;
	localparam logic [6:0] CH_M    = 7'h6D;
	localparam logic [6:0] CH_S    = 7'h73;

	localparam logic [DIV_W-1:0] ROUND_HALF = 32'd30;

	typedef struct packed {
		logic              load;
		logic [REM_W-1:0]  divisor;
	} div_cmd_t;

endpackage

### rtl/ehms_div.sv
module ehms_div
	import ehms_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  div_cmd_t         cmd,
	input  logic [DIV_W-1:0] operand,
	output logic             done,
	output logic [DIV_W-1:0] quotient,
	output logic [REM_W-1:0] remainder
);

	logic [QUO_W-1:0] quo_q;
	logic [REM_W-1:0] low_q;
	logic             sixty_q;
	logic             done_q;

	logic               sixty;
	logic [PRE_W-1:0]   pre;
	logic [RECIP_W-1:0] recip;
	logic [QUO_W-1:0]   quo_d;

	// Sixty is four times fifteen and ten is twice five, so the low bits are shifted out first.
	assign sixty = (cmd.divisor == DIV_SIXTY);
	assign pre   = sixty ? operand[DIV_W-1:2] : operand[DIV_W-2:1];
	assign recip = sixty ? RECIP_FIFTEEN : RECIP_FIVE;
	assign quo_d = QUO_W'(({{RECIP_W{1'b0}}, pre} * {{PRE_W{1'b0}}, recip}) >> RECIP_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.load;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quo_q   <= quo_d;
			low_q   <= operand[REM_W-1:0];
			sixty_q <= sixty;
		end
	end

	assign done      = done_q;
	assign quotient  = DIV_W'(quo_q);
	assign remainder = sixty_q ? (low_q + {quo_q[3:0], 2'b00}) :
		(low_q - {quo_q[2:0], 3'b000} - {quo_q[4:0], 1'b0});

endmodule

### rtl/elapsed_ticks_to_hms_text.sv
// Converts an elapsed time in sixtieths of a second, rounded to whole seconds, into the text
// "XhYmZs" with the hour part left out when it is zero. A request is taken when start is high
// and busy is low; busy then stays high until the last character has been issued. Characters
// come one per cycle on char_code, each marked by char_valid for exactly one cycle, and the
// final 's' carries last_char. The receiver cannot stall this stream. All divisions go through
// one shared unit that divides by sixty or by ten with a reciprocal multiplication, one
// division per cycle: three by sixty, one by ten for each hour digit and two for the minute
// and second digits. The first character comes after all divisions are done, and no new request
// is taken until the last character has been issued; the hour part has at most four digits.
module elapsed_ticks_to_hms_text
	import ehms_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [30:0] ticks,
	output logic        char_valid,
	output logic [6:0]  char_code,
	output logic        last_char
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_D_SECS  = 4'd1;
	localparam logic [3:0] ST_D_MINS  = 4'd2;
	localparam logic [3:0] ST_D_HR    = 4'd3;
	localparam logic [3:0] ST_D_HRDIG = 4'd4;
	localparam logic [3:0] ST_D_MIN10 = 4'd5;
	localparam logic [3:0] ST_D_SEC10 = 4'd6;
	localparam logic [3:0] ST_E_HR    = 4'd7;
	localparam logic [3:0] ST_E_H     = 4'd8;
	localparam logic [3:0] ST_E_MT    = 4'd9;
	localparam logic [3:0] ST_E_MU    = 4'd10;
	localparam logic [3:0] ST_E_M     = 4'd11;
	localparam logic [3:0] ST_E_ST    = 4'd12;
	localparam logic [3:0] ST_E_SU    = 4'd13;
	localparam logic [3:0] ST_E_S     = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;

	div_cmd_t         cmd;
	logic             div_done;
	logic [DIV_W-1:0] operand;
	logic [DIV_W-1:0] quotient;
	logic [REM_W-1:0] remainder;

	logic [REM_W-1:0] sec60_q;
	logic [REM_W-1:0] min60_q;
	logic [3:0]       hd_q [4];
	logic [2:0]       hn_q;
	logic [1:0]       hd_idx;
	logic [3:0]       mt_q;
	logic [3:0]       mu_q;
	logic [3:0]       st_q;
	logic [3:0]       su_q;
	logic [6:0]       char_q;
	logic             last_q;
	logic             valid_q;
	logic [DIV_W-1:0] ticks_sum;

	ehms_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.operand   (operand),
		.done      (div_done),
		.quotient  (quotient),
		.remainder (remainder)
	);

	assign ticks_sum = {1'b0, ticks} + ROUND_HALF;
	assign hd_idx    = hn_q[1:0] - 2'd1;

	always_comb begin
		cmd.load    = 1'b0;
		cmd.divisor = DIV_SIXTY;
		operand     = '0;
		state_d     = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					operand  = ticks_sum;
					state_d  = ST_D_SECS;
				end
			end
			ST_D_SECS: begin
				if (div_done) begin
					cmd.load = 1'b1;
					operand  = quotient;
					state_d  = ST_D_MINS;
				end
			end
			ST_D_MINS: begin
				if (div_done) begin
					cmd.load = 1'b1;
					operand  = quotient;
					state_d  = ST_D_HR;
				end
			end
			ST_D_HR, ST_D_HRDIG: begin
				if (div_done) begin
					cmd.load    = 1'b1;
					cmd.divisor = DIV_TEN;
					if (quotient != '0) begin
						operand = quotient;
						state_d = ST_D_HRDIG;
					end else begin
						operand = DIV_W'((state_q == ST_D_HR) ? remainder : min60_q);
						state_d = ST_D_MIN10;
					end
				end
			end
			ST_D_MIN10: begin
				if (div_done) begin
					cmd.load    = 1'b1;
					cmd.divisor = DIV_TEN;
					operand     = DIV_W'(sec60_q);
					state_d     = ST_D_SEC10;
				end
			end
			ST_D_SEC10: begin
				if (div_done) begin
					if (hn_q != 3'd0) begin
						state_d = ST_E_HR;
					end else if (mt_q != 4'd0) begin
						state_d = ST_E_MT;
					end else begin
						state_d = ST_E_MU;
					end
				end
			end
			ST_E_HR: begin
				if (hn_q == 3'd1) begin
					state_d = ST_E_H;
				end
			end
			ST_E_H: begin
				state_d = (mt_q != 4'd0) ? ST_E_MT : ST_E_MU;
			end
			ST_E_MT: begin
				state_d = ST_E_MU;
			end
			ST_E_MU: begin
				state_d = ST_E_M;
			end
			ST_E_M: begin
				state_d = (st_q != 4'd0) ? ST_E_ST : ST_E_SU;
			end
			ST_E_ST: begin
				state_d = ST_E_SU;
			end
			ST_E_SU: begin
				state_d = ST_E_S;
			end
			ST_E_S: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			hn_q    <= '0;
		end else begin
			state_q <= state_d;
			valid_q <= (state_q == ST_E_HR) || (state_q == ST_E_H) ||
				(state_q == ST_E_MT) || (state_q == ST_E_MU) ||
				(state_q == ST_E_M) || (state_q == ST_E_ST) ||
				(state_q == ST_E_SU) || (state_q == ST_E_S);
			if (state_q == ST_D_HR && div_done) begin
				hn_q <= '0;
			end else if (state_q == ST_D_HRDIG && div_done) begin
				hn_q <= hn_q + 3'd1;
			end else if (state_q == ST_E_HR) begin
				hn_q <= hn_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		last_q <= (state_q == ST_E_S);
		unique case (state_q)
			ST_D_MINS: begin
				if (div_done) begin
					sec60_q <= remainder;
				end
			end
			ST_D_HR: begin
				if (div_done) begin
					min60_q <= remainder;
				end
			end
			ST_D_HRDIG: begin
				if (div_done) begin
					hd_q[hn_q[1:0]] <= remainder[3:0];
				end
			end
			ST_D_MIN10: begin
				if (div_done) begin
					mt_q <= quotient[3:0];
					mu_q <= remainder[3:0];
				end
			end
			ST_D_SEC10: begin
				if (div_done) begin
					st_q <= quotient[3:0];
					su_q <= remainder[3:0];
				end
			end
			ST_E_HR: char_q <= CH_ZERO + {3'b0, hd_q[hd_idx]};
			ST_E_H:  char_q <= CH_H;
			ST_E_MT: char_q <= CH_ZERO + {3'b0, mt_q};
			ST_E_MU: char_q <= CH_ZERO + {3'b0, mu_q};
			ST_E_M:  char_q <= CH_M;
			ST_E_ST: char_q <= CH_ZERO + {3'b0, st_q};
			ST_E_SU: char_q <= CH_ZERO + {3'b0, su_q};
			ST_E_S:  char_q <= CH_S;
			default: begin
			end
		endcase
	end

	assign busy       = (state_q != ST_IDLE);
	assign char_valid = valid_q;
	assign char_code  = char_q;
	assign last_char  = last_q;

endmodule

### test/tb_elapsed_ticks_to_hms_text.sv
module tb_elapsed_ticks_to_hms_text;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 250;

	localparam logic [6:0] TXT_ZERO = 7'h30;
	localparam logic [6:0] TXT_H    = 7'h68;
	localparam logic [6:0] TXT_M    = 7'h6D;
	localparam logic [6:0] TXT_S    = 7'h73;

	localparam int unsigned TICKS_PER_SEC  = 60;
	localparam int unsigned TICKS_PER_HOUR = 216000;

	typedef struct packed {
		logic [6:0] code;
		logic       last;
	} hms_char_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [30:0] ticks;
	logic        char_valid;
	logic [6:0]  char_code;
	logic        last_char;

	hms_char_t pending_chars[$];
	int        errors;
	int        requests_taken;
	int        chars_checked;
	int        quiet_cycles;
	bit        no_gaps;

	elapsed_ticks_to_hms_text dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.ticks      (ticks),
		.char_valid (char_valid),
		.char_code  (char_code),
		.last_char  (last_char)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic void note_mismatch(input string what);
		errors++;
		if (errors <= 10) begin
			$display("%s", what);
		end
	endfunction

	// Decimal text without leading zeros, always at least one digit.
	function automatic void append_number(input int unsigned value);
		int unsigned rest;
		int unsigned div;
		int unsigned d;
		bit          started;
		rest    = value;
		started = 1'b0;
		for (div = 10000; div > 1; div = div / 10) begin
			d = rest / div;
			if (d > 9) begin
				d = 9;
			end
			if (d != 0) begin
				started = 1'b1;
			end
			if (started) begin
				pending_chars.push_back(hms_char_t'{TXT_ZERO + 7'(d), 1'b0});
			end
			rest = rest % div;
		end
		pending_chars.push_back(hms_char_t'{TXT_ZERO + 7'(rest), 1'b0});
	endfunction

	always @(posedge clk) begin : char_monitor
		hms_char_t   exp_char;
		logic [32:0] rounded;
		int unsigned secs_total;
		int unsigned mins_total;
		int unsigned hours;
		if (char_valid === 1'b1) begin
			chars_checked++;
			if (pending_chars.size() == 0) begin
				note_mismatch($sformatf("unexpected character: code %h last %b",
					char_code, last_char));
			end else begin
				exp_char = pending_chars.pop_front();
				if (exp_char.code !== char_code || exp_char.last !== last_char) begin
					note_mismatch($sformatf(
						"character mismatch: expected code %h last %b, got code %h last %b",
						exp_char.code, exp_char.last, char_code, last_char));
				end
			end
		end
		if (arst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
			requests_taken++;
			rounded    = {2'b00, ticks} + 33'd30;
			secs_total = 32'(rounded / TICKS_PER_SEC);
			mins_total = secs_total / 60;
			hours      = mins_total / 60;
			if (hours != 0) begin
				append_number(hours);
				pending_chars.push_back(hms_char_t'{TXT_H, 1'b0});
			end
			append_number(mins_total % 60);
			pending_chars.push_back(hms_char_t'{TXT_M, 1'b0});
			append_number(secs_total % 60);
			pending_chars.push_back(hms_char_t'{TXT_S, 1'b1});
			quiet_cycles = 0;
		end else if (char_valid === 1'b1) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d characters outstanding",
					pending_chars.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	// Start is kept high across back-to-back requests so that it is never
	// lowered and raised in the same step.
	task automatic send_ticks(input logic [30:0] value);
		int gap;
		int pick;
		gap = 0;
		if (!no_gaps) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				gap = 0;
			end else if (pick < 85) begin
				gap = $urandom_range(1, 4);
			end else if (pick < 95) begin
				gap = $urandom_range(5, 40);
			end else begin
				gap = $urandom_range(41, 250);
			end
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		ticks <= value;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	function automatic logic [30:0] random_ticks();
		int unsigned pick;
		int unsigned secs;
		int unsigned h;
		int unsigned m;
		int unsigned s;
		logic [31:0] v;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			v = $urandom;
		end else if (pick < 50) begin
			v = $urandom_range(0, TICKS_PER_HOUR - 1);
		end else if (pick < 70) begin
			v = $urandom >> $urandom_range(1, 31);
		end else if (pick < 88) begin
			secs = $urandom_range(0, 35791393);
			v    = secs * TICKS_PER_SEC + $urandom_range(29, 31);
		end else begin
			h = $urandom_range(0, 9941);
			case ($urandom_range(0, 2))
				0: m = 0;
				1: m = 59;
				default: m = $urandom_range(0, 59);
			endcase
			case ($urandom_range(0, 2))
				0: s = 0;
				1: s = 59;
				default: s = $urandom_range(0, 59);
			endcase
			v = (h * 3600 + m * 60 + s) * TICKS_PER_SEC + ($urandom_range(0, 1) ? 29 : 30);
		end
		return v[30:0];
	endfunction

	task automatic test_rounding_edges();
		send_ticks(31'd0);
		send_ticks(31'd29);
		send_ticks(31'd30);
		send_ticks(31'd89);
		send_ticks(31'd90);
		send_ticks(31'd3569);
		send_ticks(31'd3570);
		send_ticks(31'd215969);
		send_ticks(31'd215970);
		send_ticks(31'd216600);
	endtask

	task automatic test_hour_widths();
		send_ticks(31'(10 * TICKS_PER_HOUR - 31));
		send_ticks(31'(10 * TICKS_PER_HOUR));
		send_ticks(31'(100 * TICKS_PER_HOUR - 31));
		send_ticks(31'(100 * TICKS_PER_HOUR));
		send_ticks(31'(1000 * TICKS_PER_HOUR - 31));
		send_ticks(31'(1000 * TICKS_PER_HOUR));
		send_ticks(31'(1000 * TICKS_PER_HOUR + 3540));
	endtask

	task automatic test_bit_extremes();
		send_ticks(31'h7FFF_FFFF);
		send_ticks(31'h4000_0000);
		send_ticks(31'h2AAA_AAAA);
		send_ticks(31'h5555_5555);
		send_ticks(31'h0000_0001);
	endtask

	task automatic test_random_durations();
		no_gaps = 1'b0;
		repeat (400) send_ticks(random_ticks());
	endtask

	task automatic test_back_to_back();
		no_gaps = 1'b1;
		repeat (50) send_ticks(random_ticks());
		no_gaps = 1'b0;
	endtask

	initial begin
		errors         = 0;
		requests_taken = 0;
		chars_checked  = 0;
		quiet_cycles   = 0;
		no_gaps        = 1'b0;
		arst_n         = 1'b0;
		start          = 1'b0;
		ticks          = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_rounding_edges();
		test_hour_widths();
		test_bit_extremes();
		test_random_durations();
		test_back_to_back();

		start <= 1'b0;
		@(posedge clk);
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_chars.size() != 0) begin
			note_mismatch($sformatf("%0d expected characters never arrived",
				pending_chars.size()));
		end

		$display("Converted %0d durations, including rounding, hour-width and bit extremes,",
			requests_taken);
		$display("and checked %0d characters with %0d mismatches.", chars_checked, errors);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
